// ===== rtl/core/mrrc_pkg.sv =====
package mrrc_pkg;

  // CRC-16 (reflected) constants
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Fixed header byte and error distances
  localparam logic [7:0]  COUNT_BYTE   = 8'h02;
  localparam logic [15:0] DIST_BAD_HDR = 16'd5000;
  localparam logic [15:0] DIST_ERROR   = 16'd40000;

  // Byte positions inside a reply frame
  localparam logic [2:0] POS_ADDR    = 3'd0;
  localparam logic [2:0] POS_FUNC    = 3'd1;
  localparam logic [2:0] POS_COUNT   = 3'd2;
  localparam logic [2:0] POS_READ_HI = 3'd3;
  localparam logic [2:0] POS_READ_LO = 3'd4;
  localparam logic [2:0] POS_CRC_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_HI  = 3'd6;
  localparam logic [2:0] POS_IDLE    = 3'd7;

  // Register reset values
  localparam logic [7:0]  RST_SLAVE_ADDRESS     = 8'd1;
  localparam logic [7:0]  RST_EXPECTED_FUNCTION = 8'd3;
  localparam logic [15:0] RST_MAX_READING       = 16'd2000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Register indexes; index 3 is unused and ignored
  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS     = 2'd0,
    CFG_EXPECTED_FUNCTION = 2'd1,
    CFG_MAX_READING       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  expected_function;
    logic [15:0] max_reading;
  } cfg_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] distance;
  } result_t;

  // One byte through the reflected CRC, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrrc_cfg_regs.sv =====
module mrrc_cfg_regs
  import mrrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  // Register file, written one register per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address     <= RST_SLAVE_ADDRESS;
      cfg.expected_function <= RST_EXPECTED_FUNCTION;
      cfg.max_reading       <= RST_MAX_READING;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:     cfg.slave_address     <= cfg_data[7:0];
        CFG_EXPECTED_FUNCTION: cfg.expected_function <= cfg_data[7:0];
        CFG_MAX_READING:       cfg.max_reading       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mrrc_in_stage.sv =====
module mrrc_in_stage
  import mrrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  item_valid,
  output item_t item,
  input  logic  advance
);

  // Free when empty or when the held byte moves on this cycle
  assign s_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

// ===== rtl/core/mrrc_frame_check.sv =====
module mrrc_frame_check
  import mrrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    advance,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t result
);

  logic [2:0]  byte_position;
  logic [15:0] running_crc;
  logic        header_good;
  logic [15:0] reading_word;
  logic [7:0]  crc_low_received;

  logic [2:0]  byte_position_next;
  logic [15:0] running_crc_next;
  logic        header_good_next;
  logic [15:0] reading_word_next;
  logic [7:0]  crc_low_received_next;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic        hdr_base;
  logic [15:0] crc_step;
  logic        live;
  logic        emit;
  result_t     result_next;

  // Result slot frees when empty or taken
  assign advance = !m_valid || m_ready;

  // Start flag restarts the frame at byte 0
  assign pos      = item.frame_start ? POS_ADDR : byte_position;
  assign crc_base = item.frame_start ? CRC_SEED : running_crc;
  assign hdr_base = item.frame_start ? 1'b1 : header_good;
  assign live     = item_valid && advance && (item.frame_start || byte_position != POS_IDLE);
  assign crc_step = crc_byte(crc_base, item.rx_byte);

  // Frame state update and result decision
  always_comb begin
    byte_position_next    = byte_position;
    running_crc_next      = running_crc;
    header_good_next      = header_good;
    reading_word_next     = reading_word;
    crc_low_received_next = crc_low_received;
    emit                  = 1'b0;
    result_next           = '{status: ST_OK, distance: reading_word};
    if (live) begin
      running_crc_next   = crc_base;
      header_good_next   = hdr_base;
      byte_position_next = pos + 3'd1;
      unique case (pos)
        POS_ADDR: begin
          if (item.rx_byte != cfg.slave_address) header_good_next = 1'b0;
          running_crc_next = crc_step;
        end
        POS_FUNC: begin
          if (item.rx_byte != cfg.expected_function) header_good_next = 1'b0;
          running_crc_next = crc_step;
        end
        POS_COUNT: begin
          if (item.rx_byte != COUNT_BYTE) header_good_next = 1'b0;
          running_crc_next = crc_step;
        end
        POS_READ_HI: begin
          reading_word_next = {item.rx_byte, reading_word[7:0]};
          running_crc_next  = crc_step;
        end
        POS_READ_LO: begin
          reading_word_next = {reading_word[15:8], item.rx_byte};
          running_crc_next  = crc_step;
        end
        POS_CRC_LO: begin
          crc_low_received_next = item.rx_byte;
        end
        default: begin
          // Last CRC byte: pick the verdict, header first
          emit               = 1'b1;
          byte_position_next = POS_IDLE;
          priority if (!hdr_base) begin
            result_next = '{status: ST_BAD_HDR, distance: DIST_BAD_HDR};
          end else if ({item.rx_byte, crc_low_received} != crc_base) begin
            result_next = '{status: ST_CRC_ERR, distance: DIST_ERROR};
          end else if (reading_word > cfg.max_reading) begin
            result_next = '{status: ST_RANGE, distance: DIST_ERROR};
          end else begin
            result_next = '{status: ST_OK, distance: reading_word};
          end
        end
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_IDLE;
      running_crc      <= CRC_SEED;
      header_good      <= 1'b1;
      reading_word     <= '0;
      crc_low_received <= '0;
    end else begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      header_good      <= header_good_next;
      reading_word     <= reading_word_next;
      crc_low_received <= crc_low_received_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/modbus_read_reply_checker_unit.sv =====
// Modbus RTU read-holding-register reply checker.
// Input stream: one reply byte per transfer; tuser marks the first byte of
// a frame. Bytes 0..4 run through CRC-16 (0xA001, seed 0xFFFF), bytes 0..2
// are checked against address, function and a byte count of 2.
// Output stream: one result per complete 7-byte frame, tdata the distance,
// tuser the status (0 ok, 1 bad header, 2 CRC mismatch, 3 out of range).
// Bytes after the seventh, or before any start, are dropped silently.
// Config channel: index 0 slave address, 1 function code, 2 max reading;
// index 3 is ignored. Always ready; write only while the block is idle.
// Throughput: one byte per cycle while the result register is empty or
// being taken. After the last byte's transfer, the result passes through
// the input register, then the result register.
// Reset clears the frame tracker to idle, empties both registers and loads
// the default configuration (address 1, function 3, max 2000).
// When the receiver stalls, the held result waits and the input register
// fills; tready drops once both are occupied.
module modbus_read_reply_checker_unit
  import mrrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] distance
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;

  assign s_item = '{frame_start: s_axis_tuser, rx_byte: s_axis_tdata};

  mrrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  mrrc_frame_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .result     (result)
  );

  assign m_axis_tdata = result.distance;
  assign m_axis_tuser = result.status;

endmodule
